@@ hw/rtl/buddy_page_allocator_top_defines.svh @@
// Assertion macros used by the buddy page allocator sequencer
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define BPA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define BPA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bpa_pkg.sv @@
// Shared types, codes and defaults for the buddy page allocator
`timescale 1ns / 1ps
package bpa_pkg;

  // Default sizing
  localparam int MAX_ORDER_LEVEL_DEF = 10;
  localparam int PAGE_SHIFT_DEF      = 12;
  localparam int NUM_PAGES_DEF       = 4096;

  // Configuration register indexes
  localparam logic REG_AREA_FIRST = 1'b0;
  localparam logic REG_REGION_END = 1'b1;

  // Result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_NO_BLOCK = 3'd1;
  localparam logic [2:0] STAT_ORDER    = 3'd2;
  localparam logic [2:0] STAT_RANGE    = 3'd3;
  localparam logic [2:0] STAT_ALIGN    = 3'd4;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLR,
    DP_LOAD,
    DP_CHK,
    DP_SETP,
    DP_INC,
    DP_DEC,
    DP_TAKE,
    DP_LDT,
    DP_ABS,
    DP_UL_RD,
    DP_UL_A,
    DP_UL_B,
    DP_BM_RD,
    DP_BM_WR,
    DP_PS_A,
    DP_PS_B,
    DP_MERGE,
    DP_RES
  } dp_op_t;

  // Controller states
  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_RES,
    S_A_SEARCH,
    S_A_TAKE,
    S_A_MARK,
    S_A_LOOP,
    S_A_BUD,
    S_A_PUSH,
    S_A_FIN,
    S_F_CHK0,
    S_F_CHK1,
    S_M_LOOP,
    S_M_ABS,
    S_M_CHK,
    S_M_TEST,
    S_M_SETP,
    S_M_SETB,
    S_M_MERGE,
    S_F_FINAL,
    S_F_PUSH,
    S_F_FIN,
    S_UL_RD,
    S_UL_A,
    S_UL_B,
    S_BM_RD,
    S_BM_WR,
    S_PS_A,
    S_PS_B
  } bpa_state_t;

  // Command from controller to datapath
  typedef struct packed {
    dp_op_t     op;
    logic       sel_p;
    logic       bm_val;
    logic [2:0] status;
    logic       grant;
  } bpa_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic cmd_free;
    logic ord_bad;
    logic c_over;
    logic head_hit;
    logic c_gt_req;
    logic c_at_max;
    logic bud_out;
    logic abs_bad;
    logic bit_set;
    logic range_bad;
    logic unal;
    logic out_free;
  } bpa_flags_t;

endpackage

@@ hw/rtl/bpa_ctrl.sv @@
// Sequencer for the buddy page allocator
`timescale 1ns / 1ps
`include "buddy_page_allocator_top_defines.svh"
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  bpa_flags_t flags,
  output bpa_cmd_t   cmd
);

  bpa_state_t state, state_next;
  bpa_state_t ret, ret_next;
  logic       sel_p, sel_p_next;
  logic       bm_val, bm_val_next;
  logic [2:0] res_code, res_code_next;
  logic       res_grant, res_grant_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ret       <= S_IDLE;
      sel_p     <= 1'b0;
      bm_val    <= 1'b0;
      res_code  <= STAT_OK;
      res_grant <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      sel_p     <= sel_p_next;
      bm_val    <= bm_val_next;
      res_code  <= res_code_next;
      res_grant <= res_grant_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    ret_next       = ret;
    sel_p_next     = sel_p;
    bm_val_next    = bm_val;
    res_code_next  = res_code;
    res_grant_next = res_grant;
    in_stall       = 1'b1;
    cmd.op         = DP_NOP;
    cmd.sel_p      = sel_p;
    cmd.bm_val     = bm_val;
    cmd.status     = res_code;
    cmd.grant      = res_grant;
    unique case (state)
      S_CLEAR: begin
        cmd.op = DP_CLR;
        if (flags.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (flags.cmd_free) begin
          state_next = S_F_CHK0;
        end else if (flags.ord_bad) begin
          res_code_next  = STAT_ORDER;
          res_grant_next = 1'b0;
          state_next     = S_RES;
        end else begin
          state_next = S_A_SEARCH;
        end
      end
      S_RES: begin
        if (flags.out_free) begin
          cmd.op     = DP_RES;
          state_next = S_IDLE;
        end
      end
      // allocate: find lowest non-empty list
      S_A_SEARCH: begin
        if (flags.c_over) begin
          res_code_next  = STAT_NO_BLOCK;
          res_grant_next = 1'b0;
          state_next     = S_RES;
        end else if (flags.head_hit) begin
          state_next = S_A_TAKE;
        end else begin
          cmd.op = DP_INC;
        end
      end
      S_A_TAKE: begin
        cmd.op     = DP_TAKE;
        sel_p_next = 1'b1;
        ret_next   = S_A_MARK;
        state_next = S_UL_RD;
      end
      S_A_MARK: begin
        sel_p_next  = 1'b1;
        bm_val_next = 1'b1;
        ret_next    = S_A_LOOP;
        state_next  = S_BM_RD;
      end
      S_A_LOOP: begin
        if (flags.c_gt_req) begin
          cmd.op     = DP_DEC;
          state_next = S_A_BUD;
        end else begin
          sel_p_next  = 1'b1;
          bm_val_next = 1'b1;
          ret_next    = S_A_FIN;
          state_next  = S_BM_RD;
        end
      end
      S_A_BUD: begin
        if (flags.bud_out) begin
          state_next = S_A_LOOP;
        end else begin
          cmd.op      = DP_LDT;
          sel_p_next  = 1'b0;
          bm_val_next = 1'b0;
          ret_next    = S_A_PUSH;
          state_next  = S_BM_RD;
        end
      end
      S_A_PUSH: begin
        sel_p_next = 1'b0;
        ret_next   = S_A_LOOP;
        state_next = S_PS_A;
      end
      S_A_FIN: begin
        res_code_next  = STAT_OK;
        res_grant_next = 1'b1;
        state_next     = S_RES;
      end
      // free: checks
      S_F_CHK0: begin
        cmd.op     = DP_CHK;
        state_next = S_F_CHK1;
      end
      S_F_CHK1: begin
        cmd.op         = DP_SETP;
        res_grant_next = 1'b0;
        if (flags.range_bad) begin
          res_code_next = STAT_RANGE;
          state_next    = S_RES;
        end else if (flags.ord_bad) begin
          res_code_next = STAT_ORDER;
          state_next    = S_RES;
        end else if (flags.unal) begin
          res_code_next = STAT_ALIGN;
          state_next    = S_RES;
        end else begin
          state_next = S_M_LOOP;
        end
      end
      // free: merge with buddies
      S_M_LOOP: begin
        if (flags.c_at_max || flags.bud_out) begin
          state_next = S_F_FINAL;
        end else begin
          cmd.op     = DP_LDT;
          state_next = S_M_ABS;
        end
      end
      S_M_ABS: begin
        cmd.op     = DP_ABS;
        state_next = S_M_CHK;
      end
      S_M_CHK: begin
        if (flags.abs_bad) begin
          state_next = S_F_FINAL;
        end else begin
          cmd.op     = DP_BM_RD;
          cmd.sel_p  = 1'b0;
          state_next = S_M_TEST;
        end
      end
      S_M_TEST: begin
        if (flags.bit_set) begin
          state_next = S_F_FINAL;
        end else begin
          sel_p_next = 1'b0;
          ret_next   = S_M_SETP;
          state_next = S_UL_RD;
        end
      end
      S_M_SETP: begin
        sel_p_next  = 1'b1;
        bm_val_next = 1'b1;
        ret_next    = S_M_SETB;
        state_next  = S_BM_RD;
      end
      S_M_SETB: begin
        sel_p_next  = 1'b0;
        bm_val_next = 1'b1;
        ret_next    = S_M_MERGE;
        state_next  = S_BM_RD;
      end
      S_M_MERGE: begin
        cmd.op     = DP_MERGE;
        state_next = S_M_LOOP;
      end
      S_F_FINAL: begin
        sel_p_next  = 1'b1;
        bm_val_next = 1'b0;
        ret_next    = S_F_PUSH;
        state_next  = S_BM_RD;
      end
      S_F_PUSH: begin
        sel_p_next = 1'b1;
        ret_next   = S_F_FIN;
        state_next = S_PS_A;
      end
      S_F_FIN: begin
        res_code_next  = STAT_OK;
        res_grant_next = 1'b0;
        state_next     = S_RES;
      end
      // shared sequences: unlink, bitmap update, push
      S_UL_RD: begin
        cmd.op     = DP_UL_RD;
        state_next = S_UL_A;
      end
      S_UL_A: begin
        cmd.op     = DP_UL_A;
        state_next = S_UL_B;
      end
      S_UL_B: begin
        cmd.op     = DP_UL_B;
        state_next = ret;
      end
      S_BM_RD: begin
        cmd.op     = DP_BM_RD;
        state_next = S_BM_WR;
      end
      S_BM_WR: begin
        cmd.op     = DP_BM_WR;
        state_next = ret;
      end
      S_PS_A: begin
        cmd.op     = DP_PS_A;
        state_next = S_PS_B;
      end
      S_PS_B: begin
        cmd.op     = DP_PS_B;
        state_next = ret;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Checks
  `BPA_ASSERT_NXT(a_accept_dispatch, clk, rst, state == S_IDLE && in_valid,
                  state == S_DISPATCH, "accepted transfer not dispatched")
  `BPA_ASSERT_NXT(a_clear_holds, clk, rst, state == S_CLEAR && !flags.clr_last,
                  state == S_CLEAR, "clearing pass left early")
  `BPA_ASSERT_NXT(a_unlink_return, clk, rst, state == S_UL_B,
                  state == $past(ret), "unlink did not return to caller")
  `BPA_ASSERT_IMP(a_take_hit, clk, rst, state == S_A_TAKE,
                  flags.head_hit && !flags.c_over, "took from an empty list")

endmodule

@@ hw/rtl/bpa_datapath.sv @@
// Registers, link memories and bitmap memory of the buddy page allocator
`timescale 1ns / 1ps
module bpa_datapath
  import bpa_pkg::*;
#(
  parameter int MAX_ORDER_LEVEL = MAX_ORDER_LEVEL_DEF,
  parameter int PAGE_SHIFT      = PAGE_SHIFT_DEF,
  parameter int NUM_PAGES       = NUM_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  bpa_cmd_t    cmd,
  output bpa_flags_t  flags,
  input  logic        command,
  input  logic [31:0] block_address,
  input  logic [3:0]  block_order,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [31:0] granted_address,
  output logic [2:0]  status,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int ORDERS = MAX_ORDER_LEVEL + 1;
  localparam int PW     = $clog2(NUM_PAGES);
  localparam int LW     = PW + 1;
  localparam int OW     = $clog2(MAX_ORDER_LEVEL + 2);
  localparam int HW     = $clog2(ORDERS);
  localparam logic [PW:0]   NUM_W  = LW'(NUM_PAGES);
  localparam logic [OW-1:0] MAX_O  = OW'(MAX_ORDER_LEVEL);
  localparam logic [3:0]    MAX_IN = 4'(MAX_ORDER_LEVEL);

  logic [31:0]    area_first, region_end;
  logic           req_cmd;
  logic [31:0]    req_addr;
  logic [3:0]     req_ord;
  logic [OW-1:0]  c;
  logic [PW-1:0]  p, t;
  logic [31:0]    diff, babs;
  logic           rng_bad;
  logic [PW-1:0]  clr_cnt;
  logic [LW-1:0]  heads [ORDERS];

  // link entries hold {valid, page}
  logic [LW-1:0]     next_mem [NUM_PAGES];
  logic [LW-1:0]     prev_mem [NUM_PAGES];
  logic [ORDERS-1:0] bm_mem   [NUM_PAGES];
  logic [LW-1:0]     next_rd, prev_rd;
  logic [ORDERS-1:0] bm_rd;

  logic [31:0]       base;
  logic [HW-1:0]     c_idx;
  logic [LW-1:0]     hd;
  logic [PW-1:0]     pg, row, bud;
  logic              next_we, prev_we, bm_we;
  logic [PW-1:0]     next_wa, prev_wa, bm_wa;
  logic [LW-1:0]     next_wd, prev_wd;
  logic [ORDERS-1:0] bm_wd;

  // Common addressing
  assign base  = {area_first[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
  assign c_idx = c[HW-1:0];
  assign hd    = heads[c_idx];
  assign pg    = cmd.sel_p ? p : t;
  assign row   = pg >> c;
  assign bud   = p ^ (PW'(1) << c);

  // Status to the controller
  always_comb begin
    flags.clr_last  = (clr_cnt == PW'(NUM_PAGES - 1));
    flags.cmd_free  = req_cmd;
    flags.ord_bad   = (req_ord > MAX_IN);
    flags.c_over    = (c > MAX_O);
    flags.head_hit  = hd[PW];
    flags.c_gt_req  = (32'(c) > 32'(req_ord));
    flags.c_at_max  = (c >= MAX_O);
    flags.bud_out   = (32'(c) >= PW) || ({1'b0, bud} >= NUM_W);
    flags.abs_bad   = (babs < base) || (babs >= region_end);
    flags.bit_set   = bm_rd[c_idx];
    flags.range_bad = rng_bad || ((diff >> PAGE_SHIFT) >= 32'(NUM_PAGES));
    flags.unal      = (req_addr & ~(32'hFFFF_FFFF << (PAGE_SHIFT + 32'(req_ord)))) != 32'd0;
    flags.out_free  = !out_valid || !out_stall;
  end

  // Memory write ports
  always_comb begin
    next_we = 1'b0;
    next_wa = pg;
    next_wd = hd;
    prev_we = 1'b0;
    prev_wa = pg;
    prev_wd = '0;
    bm_we   = 1'b0;
    bm_wa   = row;
    bm_wd   = bm_rd;
    case (cmd.op)
      DP_CLR: begin
        bm_we = 1'b1;
        bm_wa = clr_cnt;
        bm_wd = '1;
      end
      DP_UL_A: begin
        if (prev_rd[PW] && ({1'b0, prev_rd[PW-1:0]} < NUM_W)) begin
          next_we = 1'b1;
          next_wa = prev_rd[PW-1:0];
          next_wd = next_rd;
        end
      end
      DP_UL_B: begin
        if (next_rd[PW] && ({1'b0, next_rd[PW-1:0]} < NUM_W)) begin
          prev_we = 1'b1;
          prev_wa = next_rd[PW-1:0];
          prev_wd = prev_rd;
        end
      end
      DP_BM_WR: begin
        bm_we        = 1'b1;
        bm_wd[c_idx] = cmd.bm_val;
      end
      DP_PS_A: begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      DP_PS_B: begin
        if (hd[PW] && ({1'b0, hd[PW-1:0]} < NUM_W)) begin
          prev_we = 1'b1;
          prev_wa = hd[PW-1:0];
          prev_wd = {1'b1, pg};
        end
      end
      default: ;
    endcase
  end

  // Link memories
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (cmd.op == DP_UL_RD) begin
      next_rd <= next_mem[pg];
      prev_rd <= prev_mem[pg];
    end
  end

  // Bitmap memory, one row per block index, one bit per order
  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    if (cmd.op == DP_BM_RD) bm_rd <= bm_mem[row];
  end

  // Control registers: config, list heads, clear counter, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      area_first <= '0;
      region_end <= '0;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < ORDERS; i++) heads[i] <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_AREA_FIRST: area_first <= cfg_data;
          REG_REGION_END: region_end <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == DP_CLR) clr_cnt <= clr_cnt + PW'(1);
      if (cmd.op == DP_UL_A && !prev_rd[PW]) heads[c_idx] <= next_rd;
      if (cmd.op == DP_PS_B) heads[c_idx] <= {1'b1, pg};
      if (cmd.op == DP_RES) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        req_cmd  <= command;
        req_addr <= block_address;
        req_ord  <= block_order;
        c        <= OW'(block_order);
      end
      DP_CHK: begin
        rng_bad <= (req_addr < base) || (req_addr >= region_end);
        diff    <= req_addr - base;
      end
      DP_SETP:  p    <= PW'(diff >> PAGE_SHIFT);
      DP_INC:   c    <= c + OW'(1);
      DP_DEC:   c    <= c - OW'(1);
      DP_TAKE:  p    <= hd[PW-1:0];
      DP_LDT:   t    <= bud;
      DP_ABS:   babs <= base + (32'(t) << PAGE_SHIFT);
      DP_MERGE: begin
        if (t < p) p <= t;
        c <= c + OW'(1);
      end
      DP_RES: begin
        granted_address <= cmd.grant ? base + (32'(p) << PAGE_SHIFT) : 32'd0;
        status          <= cmd.status;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/buddy_page_allocator_top.sv @@
// Top level of the buddy page allocator
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  command, block_address, block_order
//   result   out        out_valid/out_stall  granted_address, status
//   config   in         cfg_write            cfg_index, cfg_data
//
// After reset a clearing pass marks every block allocated;
// no transfer accepted meanwhile (config writes are taken).
// Allocate searches upward from the requested order for a non-empty list,
// takes and marks its head block, and splits it down, pushing each free
// buddy; no free block or too large an order gives an error result.
// Free checks range, order and alignment, then merges and pushes the block.
// Each step is bound by the single port of the bitmap and link memories.
// A finished result waits in the output register; the next transfer is
// accepted meanwhile and stalls only when its own result is ready.
`timescale 1ns / 1ps
module buddy_page_allocator_top
  import bpa_pkg::*;
#(
  parameter int MAX_ORDER_LEVEL = MAX_ORDER_LEVEL_DEF,
  parameter int PAGE_SHIFT      = PAGE_SHIFT_DEF,
  parameter int NUM_PAGES       = NUM_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [31:0] block_address,
  input  logic [3:0]  block_order,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] granted_address,
  output logic [2:0]  status,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  bpa_cmd_t   cmd;
  bpa_flags_t flags;

  // Sequencer
  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .flags    (flags),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  bpa_datapath #(
    .MAX_ORDER_LEVEL (MAX_ORDER_LEVEL),
    .PAGE_SHIFT      (PAGE_SHIFT),
    .NUM_PAGES       (NUM_PAGES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .flags           (flags),
    .command         (command),
    .block_address   (block_address),
    .block_order     (block_order),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .granted_address (granted_address),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

endmodule
